>>> rtl/core/slms_pkg.sv
`timescale 1ns / 1ps
package slms_pkg;
  localparam int unsigned MaxWindowDef = 8191;
  localparam int unsigned AdcBitsDef = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegWindowLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegReportWindows = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSensorScale = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCalOffset = 2'd3;
  localparam logic [12:0] WindowLengthRst = 13'd4545;
  localparam logic [7:0] ReportWindowsRst = 8'd60;
  localparam logic [14:0] SensorScaleRst = 15'd17961;
  localparam logic signed [15:0] CalOffsetRst = -16'sd6400;
  localparam logic signed [15:0] ZeroLevelDb = -16'sd25600;
  localparam logic [31:0] DbPerLog2Q16 = 32'd50504453;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;       // add the accepted sample to the running sums
    logic div_start; // mean: S / N
    logic div_step;
    logic ss_load;   // form the sum of squares (stage A)
    logic ss_fin;    // stage B
    logic log_start; // load log operand (0: SS, 1: N)
    logic log_sel;
    logic log_step;  // one squaring step
    logic db_mul;    // multiply log2 by the dB constant
    logic db_hold;   // store dB value (0: SS, 1: N)
    logic lvl;       // form the level and update the statistics
    logic avg_start;
    logic avg_step;
    logic out_load;
  } slms_cmd_t;

  typedef struct packed {
    logic win_end;
    logic ss_zero;
    logic rep_end;
  } slms_sts_t;
endpackage

>>> rtl/core/slms_datapath.sv
`timescale 1ns / 1ps
module slms_datapath import slms_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned AdcBits = AdcBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  slms_cmd_t cmd_i,
  output slms_sts_t sts_o,
  input  logic [9:0] sample_i,
  input  logic [12:0] window_length_i,
  input  logic [7:0] report_windows_i,
  input  logic [14:0] sensor_scale_i,
  input  logic signed [15:0] cal_offset_i,
  output logic signed [15:0] level_db_o,
  output logic report_valid_o,
  output logic signed [15:0] report_min_db_o,
  output logic signed [15:0] report_max_db_o,
  output logic signed [15:0] report_avg_db_o
);
  localparam int unsigned NW = $clog2(MaxWindow + 1);
  localparam int unsigned SW = NW + AdcBits;
  localparam int unsigned QW = NW + 2 * AdcBits;

  logic [AdcBits-1:0] x;
  logic [2*AdcBits-1:0] xsq;
  logic [SW-1:0] s_q;
  logic [QW-1:0] q_q;
  logic [NW-1:0] n_q;
  logic [NW-1:0] wl;
  logic [7:0] rw;

  if (AdcBits > 10) begin : g_wide
    assign x = AdcBits'(sample_i);
  end else begin : g_narrow
    assign x = sample_i[AdcBits-1:0];
  end

  assign xsq = (2*AdcBits)'(x) * (2*AdcBits)'(x);

  always_comb begin
    if (window_length_i == 13'd0) wl = NW'(1);
    else if (32'(window_length_i) > MaxWindow) wl = NW'(MaxWindow);
    else wl = NW'(window_length_i);
    rw = (report_windows_i == 8'd0) ? 8'd1 : report_windows_i;
  end

  logic [NW-1:0] n_next;
  assign n_next = n_q + NW'(1);
  assign sts_o.win_end = (n_next >= wl);

  // Restoring divider for the mean, one quotient bit per cycle.
  logic [SW-1:0] dq_q;
  logic [NW:0] dr_q;
  logic [NW:0] dtrial;
  assign dtrial = {dr_q[NW-1:0], dq_q[SW-1]};

  logic [QW+1:0] t1_q, t2_q;
  logic [QW-1:0] ss_q;

  // Products for the sum of squares; d < 2^AdcBits so these stay in range.
  logic [NW+AdcBits-1:0] nd;
  logic [SW+AdcBits-1:0] sd;
  logic [QW+1:0] ndd;
  assign nd = (NW+AdcBits)'(n_q) * (NW+AdcBits)'(dq_q[AdcBits-1:0]);
  assign sd = (SW+AdcBits)'(s_q) * (SW+AdcBits)'(dq_q[AdcBits-1:0]);
  assign ndd = t1_q * (QW+2)'(dq_q[AdcBits-1:0]);

  // Log2 unit.
  logic [31:0] m_q;
  logic [63:0] msq;
  logic [5:0] p_q;
  logic [15:0] fr_q;
  logic [QW-1:0] lx;
  logic [5:0] lp;
  logic [47:0] dbp_q;
  logic [47:0] dbprod;
  logic [15:0] dbs_q, dbn_q;
  assign msq = m_q * m_q;
  assign dbprod = 48'({p_q, fr_q}) * 48'(DbPerLog2Q16);
  assign lx = cmd_i.log_sel ? QW'(n_q) : ss_q;
  always_comb begin
    lp = '0;
    for (int i = 0; i < QW; i++) if (lx[i]) lp = 6'(i);
  end
  assign sts_o.ss_zero = (ss_q == '0);

  logic signed [15:0] pmin_q, pmax_q, lvl_q;
  logic signed [23:0] psum_q;
  logic [7:0] wcnt_q;
  logic signed [19:0] raw;
  logic signed [15:0] lvl_d;
  assign raw = 20'(signed'({4'd0, dbs_q})) - 20'(signed'({4'd0, dbn_q}))
             + 20'(signed'({5'd0, sensor_scale_i})) + 20'(cal_offset_i);
  always_comb begin
    if (sts_o.ss_zero) lvl_d = ZeroLevelDb;
    else if (raw > 20'sd32767) lvl_d = 16'sh7fff;
    else if (raw < -20'sd32768) lvl_d = -16'sh8000;
    else lvl_d = raw[15:0];
  end
  // The window being closed counts toward the period.
  assign sts_o.rep_end = (({1'b0, wcnt_q} + 9'd1) >= {1'b0, rw});

  // Signed average divider on magnitudes.
  logic [23:0] aq_q;
  logic [8:0] ar_q;
  logic [8:0] atrial;
  logic aneg_q;
  assign atrial = {ar_q[7:0], aq_q[23]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
      q_q <= '0;
      n_q <= '0;
      pmin_q <= 16'sh7fff;
      pmax_q <= -16'sh8000;
      psum_q <= '0;
      wcnt_q <= '0;
    end else begin
      if (cmd_i.acc) begin
        s_q <= s_q + SW'(x);
        q_q <= q_q + QW'(xsq);
        n_q <= n_next;
      end
      if (cmd_i.lvl) begin
        s_q <= '0;
        q_q <= '0;
        n_q <= '0;
        lvl_q <= lvl_d;
        if (sts_o.rep_end) begin
          pmin_q <= 16'sh7fff;
          pmax_q <= -16'sh8000;
          psum_q <= '0;
          wcnt_q <= '0;
        end else begin
          if (lvl_d < pmin_q) pmin_q <= lvl_d;
          if (lvl_d > pmax_q) pmax_q <= lvl_d;
          psum_q <= psum_q + 24'(lvl_d);
          wcnt_q <= wcnt_q + 8'd1;
        end
      end
    end
  end

  // The report uses the window's own level, folded in by the update below.
  logic signed [15:0] rmin, rmax;
  logic signed [23:0] rsum;
  logic [7:0] rcnt;
  logic rep_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= s_q;
      dr_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dtrial >= {1'b0, n_q}) begin
        dr_q <= dtrial - {1'b0, n_q};
        dq_q <= {dq_q[SW-2:0], 1'b1};
      end else begin
        dr_q <= dtrial;
        dq_q <= {dq_q[SW-2:0], 1'b0};
      end
    end
    if (cmd_i.ss_load) begin
      t1_q <= (QW+2)'(nd);
      t2_q <= (QW+2)'({sd, 1'b0});
    end
    if (cmd_i.ss_fin) ss_q <= QW'((QW+2)'(q_q) + ndd - t2_q);
    if (cmd_i.log_start) begin
      p_q <= lp;
      fr_q <= '0;
      m_q <= 32'((64'(lx) << 30) >> lp);
    end else if (cmd_i.log_step) begin
      if (msq[61]) begin
        m_q <= msq[62:31];
        fr_q <= {fr_q[14:0], 1'b1};
      end else begin
        m_q <= msq[61:30];
        fr_q <= {fr_q[14:0], 1'b0};
      end
    end
    if (cmd_i.db_mul) dbp_q <= dbprod + 48'h80000000;
    if (cmd_i.db_hold) begin
      if (cmd_i.log_sel) dbn_q <= dbp_q[47:32];
      else dbs_q <= dbp_q[47:32];
    end
    if (cmd_i.lvl) begin
      rmin <= (lvl_d < pmin_q) ? lvl_d : pmin_q;
      rmax <= (lvl_d > pmax_q) ? lvl_d : pmax_q;
      rsum <= psum_q + 24'(lvl_d);
      rcnt <= wcnt_q + 8'd1;
      rep_q <= sts_o.rep_end;
    end
    if (cmd_i.avg_start) begin
      aneg_q <= rsum[23];
      aq_q <= rsum[23] ? 24'(-rsum) : 24'(rsum);
      ar_q <= '0;
    end else if (cmd_i.avg_step) begin
      if (atrial >= {1'b0, rcnt}) begin
        ar_q <= atrial - {1'b0, rcnt};
        aq_q <= {aq_q[22:0], 1'b1};
      end else begin
        ar_q <= atrial;
        aq_q <= {aq_q[22:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      level_db_o <= lvl_q;
      report_valid_o <= rep_q;
      report_min_db_o <= rep_q ? rmin : 16'sd0;
      report_max_db_o <= rep_q ? rmax : 16'sd0;
      report_avg_db_o <= rep_q ?
          (aneg_q ? 16'(-aq_q) : aq_q[15:0]) : 16'sd0;
    end
  end
endmodule

>>> rtl/core/slms_ctrl.sv
`timescale 1ns / 1ps
module slms_ctrl import slms_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned AdcBits = AdcBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  slms_sts_t sts_i,
  output slms_cmd_t cmd_o
);
  localparam int unsigned SW = $clog2(MaxWindow + 1) + AdcBits;
  localparam logic [3:0] StIdle = 4'd0, StDiv = 4'd1, StSs = 4'd2, StSsFin = 4'd3,
    StLogLd = 4'd4, StLog = 4'd5, StMul = 4'd6, StHold = 4'd7, StLvl = 4'd8,
    StAvgLd = 4'd9, StAvg = 4'd10, StOut = 4'd11;

  logic [3:0] st_q, st_d;
  logic [5:0] cnt_q, cnt_d;
  logic sel_q, sel_d;
  logic ov_q, ov_d;
  logic acc;

  assign in_ready = (st_q == StIdle);
  assign out_valid = ov_q;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd_o = '0;
    st_d = st_q;
    cnt_d = cnt_q;
    sel_d = sel_q;
    ov_d = ov_q && !out_ready;
    cmd_o.acc = acc;
    cmd_o.log_sel = sel_q;
    case (st_q)
      StIdle: if (acc && sts_i.win_end) st_d = StDiv;
      StDiv: begin
        if (cnt_q == 6'd0) cmd_o.div_start = 1'b1;
        else cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SW)) begin
          cnt_d = '0;
          st_d = StSs;
        end
      end
      StSs: begin
        cmd_o.ss_load = 1'b1;
        st_d = StSsFin;
      end
      StSsFin: begin
        cmd_o.ss_fin = 1'b1;
        sel_d = 1'b0;
        st_d = StLogLd;
      end
      StLogLd: begin
        cmd_o.log_start = 1'b1;
        cnt_d = '0;
        st_d = StLog;
      end
      StLog: begin
        cmd_o.log_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd15) st_d = StMul;
      end
      StMul: begin
        cmd_o.db_mul = 1'b1;
        st_d = StHold;
      end
      StHold: begin
        cmd_o.db_hold = 1'b1;
        if (sel_q) st_d = StLvl;
        else begin
          sel_d = 1'b1;
          st_d = StLogLd;
        end
      end
      StLvl: begin
        cmd_o.lvl = 1'b1;
        st_d = StAvgLd;
      end
      StAvgLd: begin
        cmd_o.avg_start = 1'b1;
        cnt_d = '0;
        st_d = StAvg;
      end
      StAvg: begin
        cmd_o.avg_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd23) st_d = StOut;
      end
      StOut: if (!ov_q) begin
        cmd_o.out_load = 1'b1;
        ov_d = 1'b1;
        cnt_d = '0;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      sel_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      sel_q <= sel_d;
      ov_q <= ov_d;
    end
  end
endmodule

>>> rtl/core/sound_level_meter_stats.sv
`timescale 1ns / 1ps
// Sound level meter. Sample items are accepted while a window fills; the item
// that closes a window starts a sequence through the bit-serial mean divider,
// the shared squaring log2 unit used twice, and the bit-serial average
// divider. During that sequence no new item is taken; the level and report
// then wait in the output register while sample items of the next window keep
// coming in. A window that closes while the previous result still waits holds
// in its last step until that result has been taken.
module sound_level_meter_stats import slms_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned AdcBits = AdcBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [9:0] sample_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [15:0] level_db_o,
  output logic report_valid_o,
  output logic signed [15:0] report_min_db_o,
  output logic signed [15:0] report_max_db_o,
  output logic signed [15:0] report_avg_db_o
);
  logic [12:0] wl_q;
  logic [7:0] rw_q;
  logic [14:0] sc_q;
  logic signed [15:0] cal_q;
  slms_cmd_t cmd;
  slms_sts_t sts;

  // Configuration registers, to be written by the user only while idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WindowLengthRst;
      rw_q <= ReportWindowsRst;
      sc_q <= SensorScaleRst;
      cal_q <= CalOffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWindowLength: wl_q <= cfg_data_i[12:0];
        RegReportWindows: rw_q <= cfg_data_i[7:0];
        RegSensorScale: sc_q <= cfg_data_i[14:0];
        RegCalOffset: cal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  slms_ctrl #(.MaxWindow(MaxWindow), .AdcBits(AdcBits)) u_ctrl (
    .clk_i, .rst_ni, .in_valid(in_valid_i), .in_ready(in_ready_o),
    .out_valid(out_valid_o), .out_ready(out_ready_i), .sts_i(sts), .cmd_o(cmd)
  );

  slms_datapath #(.MaxWindow(MaxWindow), .AdcBits(AdcBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .sample_i,
    .window_length_i(wl_q), .report_windows_i(rw_q), .sensor_scale_i(sc_q),
    .cal_offset_i(cal_q), .level_db_o, .report_valid_o, .report_min_db_o,
    .report_max_db_o, .report_avg_db_o
  );
endmodule

>>> tb/slms_checker.sv
`timescale 1ns / 1ps
module slms_checker import slms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic [9:0] sample_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  logic signed [15:0] level_db_i,
  input  logic report_valid_i,
  input  logic signed [15:0] report_min_db_i,
  input  logic signed [15:0] report_max_db_i,
  input  logic signed [15:0] report_avg_db_i,
  output int fail_cnt_o,
  output int pending_o,
  output int in_cnt_o,
  output int out_cnt_o
);

  typedef struct {
    logic signed [15:0] level;
    logic rep;
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    logic signed [15:0] avg;
  } window_level_t;

  window_level_t expected_windows[$];

  logic [12:0] win_len;
  logic [7:0] rep_windows;
  logic [14:0] scale_db;
  logic signed [15:0] cal_db;

  longint unsigned acc_sum, acc_sq, acc_cnt;
  longint per_min, per_max, per_sum;
  int per_windows;

  assign pending_o = expected_windows.size();

  function automatic longint unsigned log2_q16(longint unsigned x);
    longint unsigned m, frac;
    int p;
    frac = 0;
    p = 0;
    if (x == 0) return 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    if (p >= 30) m = x >> (p - 30);
    else m = x << (30 - p);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac |= 64'd1 << i;
      end
    end
    return (longint'(p) << 16) | frac;
  endfunction

  function automatic longint db_of(longint unsigned x);
    longint unsigned t;
    t = (log2_q16(x) * 64'd50504453 + (64'd1 << 31)) >> 32;
    return longint'(t);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  task automatic take_sample(input logic [9:0] s);
    longint unsigned wl, n, d, ss;
    longint lvl;
    window_level_t r;
    wl = (win_len == 0) ? 1 : win_len;
    acc_sum += s;
    acc_sq += longint'(s) * longint'(s);
    acc_cnt++;
    if (acc_cnt < wl) return;
    n = acc_cnt;
    d = acc_sum / n;
    ss = acc_sq + n * d * d - 2 * d * acc_sum;
    if (ss == 0) begin
      lvl = ZeroLevelDb;
    end else begin
      lvl = db_of(ss) - db_of(n) + longint'(scale_db) + longint'(cal_db);
      if (lvl > 32767) lvl = 32767;
      if (lvl < -32768) lvl = -32768;
    end
    acc_sum = 0;
    acc_sq = 0;
    acc_cnt = 0;
    if (lvl < per_min) per_min = lvl;
    if (lvl > per_max) per_max = lvl;
    per_sum += lvl;
    per_windows++;
    r.level = lvl[15:0];
    if (per_windows >= ((rep_windows == 0) ? 1 : rep_windows)) begin
      r.rep = 1'b1;
      r.mn = per_min[15:0];
      r.mx = per_max[15:0];
      lvl = per_sum / per_windows;
      r.avg = lvl[15:0];
      per_min = 32767;
      per_max = -32768;
      per_sum = 0;
      per_windows = 0;
    end else begin
      r.rep = 1'b0;
      r.mn = '0;
      r.mx = '0;
      r.avg = '0;
    end
    expected_windows.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_level_t w;
    if (!rst_ni) begin
      win_len = WindowLengthRst;
      rep_windows = ReportWindowsRst;
      scale_db = SensorScaleRst;
      cal_db = CalOffsetRst;
      acc_sum = 0;
      acc_sq = 0;
      acc_cnt = 0;
      per_min = 32767;
      per_max = -32768;
      per_sum = 0;
      per_windows = 0;
      expected_windows.delete();
      fail_cnt_o = 0;
      in_cnt_o <= 0;
      out_cnt_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        out_cnt_o <= out_cnt_o + 1;
        if (expected_windows.size() == 0) begin
          report_mismatch("unexpected result, level", level_db_i, 0);
        end else begin
          w = expected_windows.pop_front();
          if (level_db_i !== w.level) report_mismatch("level_db", level_db_i, w.level);
          if (report_valid_i !== w.rep) report_mismatch("report_valid", report_valid_i, w.rep);
          if (report_min_db_i !== w.mn) report_mismatch("report_min_db", report_min_db_i, w.mn);
          if (report_max_db_i !== w.mx) report_mismatch("report_max_db", report_max_db_i, w.mx);
          if (report_avg_db_i !== w.avg) report_mismatch("report_avg_db", report_avg_db_i, w.avg);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWindowLength: win_len = cfg_data_i[12:0];
          RegReportWindows: rep_windows = cfg_data_i[7:0];
          RegSensorScale: scale_db = cfg_data_i[14:0];
          RegCalOffset: cal_db = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        in_cnt_o <= in_cnt_o + 1;
        take_sample(sample_i);
      end
    end
  end

endmodule

>>> tb/tb_sound_level_meter_stats.sv
`timescale 1ns / 1ps
// Testbench top: drives sample items and register writes into the meter,
// shapes backpressure on the result channel, and gives the verdict. All
// prediction and comparison lives in the checker instantiated beside the
// block.
module tb_sound_level_meter_stats import slms_pkg::*;;

  // Cycles without any accepted item before the run is declared hung. The
  // worst case is the long receiver hold plus one window-end sequence.
  localparam int IdleLimit = 3000;
  // Cycles to let a window-end sequence drain before a register write.
  localparam int SettleCycles = 120;
  localparam int RandomItems = 750;
  localparam int LongWindow = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegWindowLength;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [9:0] sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] level_db_o;
  logic report_valid_o;
  logic signed [15:0] report_min_db_o;
  logic signed [15:0] report_max_db_o;
  logic signed [15:0] report_avg_db_o;

  int fail_cnt, pending, in_cnt, out_cnt;
  int burst_left = 0;
  int sent_random = 0;
  // The receiver process answers a hold request by comparing these two.
  int hold_req = 0;
  int hold_ack = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sound_level_meter_stats u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_i,
    .out_valid_o, .out_ready_i,
    .level_db_o, .report_valid_o, .report_min_db_o, .report_max_db_o,
    .report_avg_db_o
  );

  slms_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .sample_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .level_db_i(level_db_o), .report_valid_i(report_valid_o),
    .report_min_db_i(report_min_db_o), .report_max_db_i(report_max_db_o),
    .report_avg_db_i(report_avg_db_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .in_cnt_o(in_cnt), .out_cnt_o(out_cnt)
  );

  // The sender stops until every expected window result has been taken, then
  // leaves room for a window-end sequence that produces nothing visible yet.
  task automatic drain_and_wait();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One register write, issued at a falling edge while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input int wl, input int rw, input int scale, input int cal);
    write_reg(RegWindowLength, CfgDataW'(wl));
    write_reg(RegReportWindows, CfgDataW'(rw));
    write_reg(RegSensorScale, CfgDataW'(scale));
    write_reg(RegCalOffset, CfgDataW'(cal));
  endtask

  // Offer one sample item. The sender works in bursts; between most bursts valid
  // drops for a random gap. Acceptance is seen through the checker's count,
  // which only moves at a rising edge, so the falling-edge test is race-free.
  task automatic send_sample(input logic [9:0] s);
    int before_cnt;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    burst_left--;
    before_cnt = in_cnt;
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(negedge clk_i); while (in_cnt == before_cnt);
  endtask

  // Random sample with a mix of shapes: quiet constant input (zero signal),
  // rail-to-rail swings, small wobble around a base value and plain noise.
  function automatic logic [9:0] pick_sample(input int shape, input logic [9:0] base);
    case (shape)
      0: return base;
      1: return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
      2: return base ^ 10'($urandom_range(0, 3));
      default: return 10'($urandom);
    endcase
  endfunction

  // Receiver: stalls on a pattern that changes every so often, and on request
  // holds off for a long stretch so that the block fills and stalls its input.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        out_ready_i <= 1'b0;
        repeat (500) @(negedge clk_i);
        hold_ack = hold_req;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 150);
      end
      left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) != 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: counts cycles in which neither channel accepts an item.
  initial begin
    int idle, last_in, last_out;
    idle = 0;
    last_in = 0;
    last_out = 0;
    forever begin
      @(negedge clk_i);
      if (in_cnt != last_in || out_cnt != last_out) idle = 0;
      else idle++;
      last_in = in_cnt;
      last_out = out_cnt;
      if (idle >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int wl, rw, shape, count;
    logic [9:0] base;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    drain_and_wait();

    // Single-sample windows always give a zero signal.
    set_all(1, 1, 0, 0);
    send_sample(10'd0);
    send_sample(10'd1023);
    // Two-sample windows across the sample range and alternating bit patterns.
    drain_and_wait();
    set_all(2, 3, 17961, -6400);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'h155);
    send_sample(10'h2AA);
    send_sample(10'd1);
    send_sample(10'd0);
    // A window length of zero acts as one; a report count of zero as one.
    drain_and_wait();
    set_all(0, 0, 100, 50);
    send_sample(10'd5);
    // Level saturates at the top and at the bottom.
    drain_and_wait();
    set_all(2, 2, 32767, 32767);
    send_sample(10'd0);
    send_sample(10'd1023);
    drain_and_wait();
    set_all(2, 1, 0, -32768);
    send_sample(10'd0);
    send_sample(10'd1);
    // Window shrunk below the samples already taken: the next sample ends it.
    drain_and_wait();
    write_reg(RegWindowLength, CfgDataW'(5));
    send_sample(10'd100);
    send_sample(10'd900);
    send_sample(10'd300);
    drain_and_wait();
    write_reg(RegWindowLength, CfgDataW'(2));
    send_sample(10'd700);
    // Report count shrunk below the windows already counted.
    drain_and_wait();
    set_all(1, 4, 2000, -1000);
    send_sample(10'd1);
    send_sample(10'd2);
    send_sample(10'd3);
    drain_and_wait();
    write_reg(RegReportWindows, CfgDataW'(2));
    send_sample(10'd4);

    // Long receiver hold while short windows keep coming in.
    drain_and_wait();
    set_all(2, 3, 12000, -3000);
    hold_req++;
    for (int i = 0; i < 60; i++) send_sample(10'($urandom));

    // Random phases: new settings, then a run of samples.
    while (sent_random < RandomItems) begin
      drain_and_wait();
      case ($urandom_range(0, 9))
        0: set_all(1, 255, $urandom_range(0, 32767), 16'($urandom));
        1: set_all(0, 0, 32767, 32767);
        2: set_all($urandom_range(1, 3), 1, 0, -32768);
        default: begin
          wl = $urandom_range(1, 12);
          rw = $urandom_range(1, 6);
          if ($urandom_range(0, 1) != 0) write_reg(RegWindowLength, CfgDataW'(wl));
          if ($urandom_range(0, 1) != 0) write_reg(RegReportWindows, CfgDataW'(rw));
          if ($urandom_range(0, 1) != 0) begin
            write_reg(RegSensorScale, CfgDataW'($urandom_range(0, 32767)));
          end
          if ($urandom_range(0, 1) != 0) write_reg(RegCalOffset, 16'($urandom));
        end
      endcase
      count = $urandom_range(20, 300);
      shape = $urandom_range(0, 4);
      base = 10'($urandom);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 15) == 0) shape = $urandom_range(0, 4);
        send_sample(pick_sample(shape, base));
      end
      sent_random += count;
    end

    // One long window of rail-to-rail swings, for large running sums.
    drain_and_wait();
    set_all(LongWindow, 1, 17961, -6400);
    base = 10'($urandom);
    for (int i = 0; i < LongWindow; i++) send_sample(pick_sample(1, base));

    drain_and_wait();
    repeat (200) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sound_level_meter_stats.f
rtl/core/slms_pkg.sv
rtl/core/slms_datapath.sv
rtl/core/slms_ctrl.sv
rtl/core/sound_level_meter_stats.sv
tb/slms_checker.sv
tb/tb_sound_level_meter_stats.sv
